// ===== rtl/q9jac_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, selector codes and control types of the nine-node Jacobian evaluator.
package q9jac_pkg;

   localparam int COORD_W = 16;
   localparam int NODE_W  = 4;
   localparam int XY_W    = 32;
   localparam int OUT_W   = 40;
   localparam int ACC_W   = 48;
   localparam int WGT_W   = 18;
   localparam int FRAC    = 14;

   localparam int MUL_AW  = 32;
   localparam int MUL_BW  = 20;
   localparam int MUL_DW  = 4;
   localparam int MUL_ND  = MUL_BW / MUL_DW;
   localparam int MUL_CW  = $clog2(MUL_ND + 1);
   localparam int PROD_W  = MUL_AW + MUL_BW;
   localparam int TERM_W  = PROD_W - FRAC;

   localparam logic [NODE_W-1:0] LAST_NODE = 4'd8;

   typedef enum logic [1:0] {
      SEL_X_KSI = 2'd0,
      SEL_X_ETA = 2'd1,
      SEL_Y_KSI = 2'd2,
      SEL_Y_ETA = 2'd3
   } acc_sel_type;

   typedef struct packed {
      logic        add;
      acc_sel_type sel;
      logic        flush;
   } acc_ctl_type;

endpackage

// ===== rtl/q9jac_sermul.sv =====
`timescale 1ns / 1ps
// Digit-serial signed multiplier that retires four multiplier bits per cycle.
module q9jac_sermul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [q9jac_pkg::MUL_AW-1:0]  a,
   input  logic signed [q9jac_pkg::MUL_BW-1:0]  b,
   output logic                                 done,
   output logic signed [q9jac_pkg::PROD_W-1:0]  product
);
   import q9jac_pkg::*;

   localparam int UW = MUL_AW + MUL_DW + 1;

   logic signed [MUL_AW-1:0] a_ff, a_in;
   logic signed [UW-1:0]     u_ff, u_in;
   logic [MUL_BW-1:0]        l_ff, l_in;
   logic [MUL_CW-1:0]        cnt_ff, cnt_in;
   logic                     done_ff, done_in;

   logic                     last;
   logic signed [MUL_DW:0]   dig;
   logic signed [UW-1:0]     pp;
   logic signed [UW-1:0]     sum;

   always_comb begin
      last = (cnt_ff == MUL_CW'(1));
      dig  = $signed({last & l_ff[MUL_DW-1], l_ff[MUL_DW-1:0]});
      pp   = UW'(a_ff) * UW'(dig);
      sum  = u_ff + pp;
      a_in   = a_ff;
      u_in   = u_ff;
      l_in   = l_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         u_in   = '0;
         l_in   = b;
         cnt_in = MUL_CW'(MUL_ND);
      end else if (cnt_ff != '0) begin
         u_in    = sum >>> MUL_DW;
         l_in    = {sum[MUL_DW-1:0], l_ff[MUL_BW-1:MUL_DW]};
         cnt_in  = cnt_ff - MUL_CW'(1);
         done_in = last;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      u_ff <= u_in;
      l_ff <= l_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = $signed({u_ff[MUL_AW-1:0], l_ff});

endmodule

// ===== rtl/q9jac_accum.sv =====
`timescale 1ns / 1ps
// Four saturating Jacobian accumulators with saturated 40-bit read-out.
module q9jac_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  q9jac_pkg::acc_ctl_type               ctl,
   input  logic signed [q9jac_pkg::PROD_W-1:0]  product,
   output logic signed [q9jac_pkg::OUT_W-1:0]   dx_dksi,
   output logic signed [q9jac_pkg::OUT_W-1:0]   dx_deta,
   output logic signed [q9jac_pkg::OUT_W-1:0]   dy_dksi,
   output logic signed [q9jac_pkg::OUT_W-1:0]   dy_deta
);
   import q9jac_pkg::*;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic signed [ACC_W-1:0] acc_ff [4];
   logic signed [ACC_W-1:0] acc_in [4];

   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  cur;
   logic signed [ACC_W:0]    sum;
   logic signed [ACC_W-1:0]  sat;

   function automatic logic signed [OUT_W-1:0] out_sat(input logic signed [ACC_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v[ACC_W-1:OUT_W-1] == '0 || v[ACC_W-1:OUT_W-1] == '1) begin
         r = v[OUT_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = OUT_MIN;
      end else begin
         r = OUT_MAX;
      end
      return r;
   endfunction

   always_comb begin
      term = $signed(product[PROD_W-1:FRAC]);
      cur  = acc_ff[ctl.sel];
      sum  = (ACC_W+1)'(cur) + (ACC_W+1)'(term);
      if (sum[ACC_W] == sum[ACC_W-1]) begin
         sat = sum[ACC_W-1:0];
      end else if (sum[ACC_W]) begin
         sat = ACC_MIN;
      end else begin
         sat = ACC_MAX;
      end
      for (int i = 0; i < 4; i++) begin
         acc_in[i] = acc_ff[i];
         if (ctl.flush) begin
            acc_in[i] = '0;
         end else if (ctl.add && ctl.sel == acc_sel_type'(i)) begin
            acc_in[i] = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (reset) begin
            acc_ff[i] <= '0;
         end else begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   assign dx_dksi = out_sat(acc_ff[SEL_X_KSI]);
   assign dx_deta = out_sat(acc_ff[SEL_X_ETA]);
   assign dy_dksi = out_sat(acc_ff[SEL_Y_KSI]);
   assign dy_deta = out_sat(acc_ff[SEL_Y_ETA]);

endmodule

// ===== rtl/quad9_jacobian_eval_core.sv =====
`timescale 1ns / 1ps
// Jacobian evaluator for a nine-node biquadratic quadrilateral, one node per item.
//
// Each item carries the reference point and one node; node 8 completes the element and
// produces one result item with the four Jacobian entries, after which the sums restart
// from zero. Items with a node index above 8 are accepted and dropped. All
// nine products of a node item (five reference-point products, then four weight-times-
// coordinate products) run through one shared 32 by 4 bit digit-serial multiplier, so
// the block accepts no new item until the last product of a node item is done, and
// node 8 then also waits in the output state until the result register is free. The
// result register lets the block accept the next item while a result still waits
// to be taken.
module quad9_jacobian_eval_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [q9jac_pkg::COORD_W-1:0]  req_ksi_coord,
   input  logic signed [q9jac_pkg::COORD_W-1:0]  req_eta_coord,
   input  logic [q9jac_pkg::NODE_W-1:0]          req_node_index,
   input  logic signed [q9jac_pkg::XY_W-1:0]     req_node_x,
   input  logic signed [q9jac_pkg::XY_W-1:0]     req_node_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [q9jac_pkg::OUT_W-1:0]    rsp_dx_dksi,
   output logic signed [q9jac_pkg::OUT_W-1:0]    rsp_dx_deta,
   output logic signed [q9jac_pkg::OUT_W-1:0]    rsp_dy_dksi,
   output logic signed [q9jac_pkg::OUT_W-1:0]    rsp_dy_deta
);
   import q9jac_pkg::*;

   localparam int SUM_W = 24;
   localparam int Q_W   = 19;
   localparam logic signed [SUM_W-1:0] ONE   = 24'sd16384;
   localparam logic signed [SUM_W-1:0] W_MAX = 24'sd131071;
   localparam logic signed [SUM_W-1:0] W_MIN = -24'sd131072;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_WAIT  = 5'b00100,
      ST_WGT   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      OP_KK  = 4'd0,
      OP_EE  = 4'd1,
      OP_KE  = 4'd2,
      OP_K2E = 4'd3,
      OP_KE2 = 4'd4,
      OP_WKX = 4'd5,
      OP_WEX = 4'd6,
      OP_WKY = 4'd7,
      OP_WEY = 4'd8
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic signed [COORD_W-1:0] k_ff, k_in, e_ff, e_in;
   logic [NODE_W-1:0]         node_ff, node_in;
   logic signed [XY_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [Q_W-1:0]     k2_ff, k2_in, e2_ff, e2_in, ke_ff, ke_in;
   logic signed [Q_W-1:0]     k2e_ff, k2e_in, ke2_ff, ke2_in;
   logic signed [WGT_W-1:0]   wk_ff, wk_in, we_ff, we_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]   dxk_ff, dxk_in, dxe_ff, dxe_in;
   logic signed [OUT_W-1:0]   dyk_ff, dyk_in, dye_ff, dye_in;

   logic                      mul_start, mul_done;
   logic signed [MUL_AW-1:0]  mul_a;
   logic signed [MUL_BW-1:0]  mul_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [Q_W-1:0]     q;
   acc_ctl_type               acc_ctl;
   logic signed [OUT_W-1:0]   sum_dxk, sum_dxe, sum_dyk, sum_dye;

   logic signed [SUM_W-1:0]   t_k, t_e, t_k2, t_e2, d_ke, d_k2e, d_ke2, d_k, d_e;
   logic signed [SUM_W-1:0]   s_k, s_e;
   logic                      neg;
   logic [1:0]                sh;
   logic                      accept, slot_free;

   function automatic logic signed [WGT_W-1:0] weight(input logic signed [SUM_W-1:0] s,
                                                      input logic neg_s,
                                                      input logic [1:0] sh_s);
      logic signed [SUM_W-1:0] v;
      logic signed [WGT_W-1:0] r;
      v = neg_s ? -s : s;
      v = v >>> sh_s;
      if (v > W_MAX) begin
         r = W_MAX[WGT_W-1:0];
      end else if (v < W_MIN) begin
         r = W_MIN[WGT_W-1:0];
      end else begin
         r = v[WGT_W-1:0];
      end
      return r;
   endfunction

   q9jac_sermul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (product)
   );

   q9jac_accum u_acc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .product (product),
      .dx_dksi (sum_dxk),
      .dx_deta (sum_dxe),
      .dy_dksi (sum_dyk),
      .dy_deta (sum_dye)
   );

   always_comb begin
      t_k   = SUM_W'(k_ff);
      t_e   = SUM_W'(e_ff);
      t_k2  = SUM_W'(k2_ff);
      t_e2  = SUM_W'(e2_ff);
      d_ke  = SUM_W'(ke_ff) <<< 1;
      d_k2e = SUM_W'(k2e_ff) <<< 1;
      d_ke2 = SUM_W'(ke2_ff) <<< 1;
      d_k   = t_k <<< 1;
      d_e   = t_e <<< 1;
      case (node_ff)
         4'd0: begin
            s_k = t_e - d_ke - t_e2 + d_ke2;
            s_e = t_k - t_k2 - d_ke + d_k2e;
            neg = 1'b0;
            sh  = 2'd2;
         end
         4'd1: begin
            s_k = t_e + d_ke - t_e2 - d_ke2;
            s_e = t_k + t_k2 - d_ke - d_k2e;
            neg = 1'b1;
            sh  = 2'd2;
         end
         4'd2: begin
            s_k = t_e + d_ke + t_e2 + d_ke2;
            s_e = t_k + t_k2 + d_ke + d_k2e;
            neg = 1'b0;
            sh  = 2'd2;
         end
         4'd3: begin
            s_k = t_e - d_ke + t_e2 - d_ke2;
            s_e = t_k - t_k2 + d_ke - d_k2e;
            neg = 1'b1;
            sh  = 2'd2;
         end
         4'd4: begin
            s_k = d_ke2 - d_ke;
            s_e = ONE - t_k2 - d_e + d_k2e;
            neg = 1'b1;
            sh  = 2'd1;
         end
         4'd5: begin
            s_k = ONE - t_e2 + d_k - d_ke2;
            s_e = -d_ke - d_k2e;
            neg = 1'b0;
            sh  = 2'd1;
         end
         4'd6: begin
            s_k = -d_ke - d_ke2;
            s_e = ONE - t_k2 + d_e - d_k2e;
            neg = 1'b0;
            sh  = 2'd1;
         end
         4'd7: begin
            s_k = ONE - t_e2 - d_k + d_ke2;
            s_e = d_k2e - d_ke;
            neg = 1'b1;
            sh  = 2'd1;
         end
         default: begin
            s_k = d_ke2 - d_k;
            s_e = d_k2e - d_e;
            neg = 1'b0;
            sh  = 2'd0;
         end
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_KK: begin
            mul_a = MUL_AW'(k_ff);
            mul_b = MUL_BW'(k_ff);
         end
         OP_EE: begin
            mul_a = MUL_AW'(e_ff);
            mul_b = MUL_BW'(e_ff);
         end
         OP_KE: begin
            mul_a = MUL_AW'(k_ff);
            mul_b = MUL_BW'(e_ff);
         end
         OP_K2E: begin
            mul_a = MUL_AW'(k2_ff);
            mul_b = MUL_BW'(e_ff);
         end
         OP_KE2: begin
            mul_a = MUL_AW'(e2_ff);
            mul_b = MUL_BW'(k_ff);
         end
         OP_WKX: begin
            mul_a = x_ff;
            mul_b = MUL_BW'(wk_ff);
         end
         OP_WEX: begin
            mul_a = x_ff;
            mul_b = MUL_BW'(we_ff);
         end
         OP_WKY: begin
            mul_a = y_ff;
            mul_b = MUL_BW'(wk_ff);
         end
         default: begin
            mul_a = y_ff;
            mul_b = MUL_BW'(we_ff);
         end
      endcase
   end

   always_comb begin
      accept    = req_valid && req_ready;
      slot_free = !rsp_valid_ff || rsp_ready;
      q         = product[FRAC +: Q_W];

      state_in = state_ff;
      op_in    = op_ff;
      k_in     = k_ff;
      e_in     = e_ff;
      node_in  = node_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k2_in    = k2_ff;
      e2_in    = e2_ff;
      ke_in    = ke_ff;
      k2e_in   = k2e_ff;
      ke2_in   = ke2_ff;
      wk_in    = wk_ff;
      we_in    = we_ff;
      dxk_in   = dxk_ff;
      dxe_in   = dxe_ff;
      dyk_in   = dyk_ff;
      dye_in   = dye_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      mul_start     = 1'b0;
      acc_ctl.add   = 1'b0;
      acc_ctl.flush = 1'b0;
      case (op_ff)
         OP_WKX:  acc_ctl.sel = SEL_X_KSI;
         OP_WEX:  acc_ctl.sel = SEL_X_ETA;
         OP_WKY:  acc_ctl.sel = SEL_Y_KSI;
         default: acc_ctl.sel = SEL_Y_ETA;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_node_index <= LAST_NODE) begin
               k_in     = req_ksi_coord;
               e_in     = req_eta_coord;
               node_in  = req_node_index;
               x_in     = req_node_x;
               y_in     = req_node_y;
               op_in    = OP_KK;
               state_in = ST_START;
            end
         end
         ST_START: begin
            mul_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  OP_KK:   k2_in  = q;
                  OP_EE:   e2_in  = q;
                  OP_KE:   ke_in  = q;
                  OP_K2E:  k2e_in = q;
                  OP_KE2:  ke2_in = q;
                  default: acc_ctl.add = 1'b1;
               endcase
               if (op_ff == OP_KE2) begin
                  state_in = ST_WGT;
               end else if (op_ff == OP_WEY) begin
                  state_in = (node_ff == LAST_NODE) ? ST_OUT : ST_IDLE;
               end else begin
                  op_in    = op_type'(op_ff + 4'd1);
                  state_in = ST_START;
               end
            end
         end
         ST_WGT: begin
            wk_in    = weight(s_k, neg, sh);
            we_in    = weight(s_e, neg, sh);
            op_in    = OP_WKX;
            state_in = ST_START;
         end
         ST_OUT: begin
            if (slot_free) begin
               dxk_in        = sum_dxk;
               dxe_in        = sum_dxe;
               dyk_in        = sum_dyk;
               dye_in        = sum_dye;
               rsp_valid_in  = 1'b1;
               acc_ctl.flush = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      e_ff   <= e_in;
      node_ff <= node_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      k2_ff  <= k2_in;
      e2_ff  <= e2_in;
      ke_ff  <= ke_in;
      k2e_ff <= k2e_in;
      ke2_ff <= ke2_in;
      wk_ff  <= wk_in;
      we_ff  <= we_in;
      dxk_ff <= dxk_in;
      dxe_ff <= dxe_in;
      dyk_ff <= dyk_in;
      dye_ff <= dye_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_KK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dx_dksi = dxk_ff;
   assign rsp_dx_deta = dxe_ff;
   assign rsp_dy_dksi = dyk_ff;
   assign rsp_dy_deta = dye_ff;

   // A product can only complete while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_WAIT)
      else $error("multiplier finished outside the wait state");

   // A new result item appears only after the sequencer handed the sums over.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result item raised without a completed element");

   // An accepted node item always starts with the first reference-point product.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_node_index <= LAST_NODE
      |=> state_ff == ST_START && op_ff == OP_KK)
      else $error("accepted item did not start its product sequence");

endmodule

// ===== tb/tb_quad9_jacobian_eval_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the nine-node Jacobian evaluator with its own predictor.
module tb_quad9_jacobian_eval_core;
   import q9jac_pkg::*;

   localparam int ITEM_TARGET  = 1800;
   localparam int STALL_LIMIT  = 20000;
   localparam int LONG_HOLD    = 3000;
   localparam int TAIL_CYCLES  = 200;
   localparam int OVERFLOW_RUN = 80;

   localparam logic [NODE_W-1:0] NODE_SW     = 4'd0;
   localparam logic [NODE_W-1:0] NODE_SE     = 4'd1;
   localparam logic [NODE_W-1:0] NODE_NE     = 4'd2;
   localparam logic [NODE_W-1:0] NODE_NW     = 4'd3;
   localparam logic [NODE_W-1:0] NODE_S      = 4'd4;
   localparam logic [NODE_W-1:0] NODE_E      = 4'd5;
   localparam logic [NODE_W-1:0] NODE_N      = 4'd6;
   localparam logic [NODE_W-1:0] NODE_WEST   = 4'd7;
   localparam logic [NODE_W-1:0] UNUSED_NODE = 4'd15;

   localparam longint ONE_Q14 = longint'(1) <<< FRAC;
   localparam longint WGT_MAX = (longint'(1) <<< (WGT_W - 1)) - 1;
   localparam longint WGT_MIN = -WGT_MAX - 1;
   localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;
   localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   typedef struct {
      logic signed [OUT_W-1:0] dx_dksi;
      logic signed [OUT_W-1:0] dx_deta;
      logic signed [OUT_W-1:0] dy_dksi;
      logic signed [OUT_W-1:0] dy_deta;
   } jacobian_type;

   class jacobian_tracker;
      jacobian_type pending_jacobians[$];
      longint sum_x_ksi;
      longint sum_x_eta;
      longint sum_y_ksi;
      longint sum_y_eta;
      int errors;
      int results_checked;

      function new();
         sum_x_ksi = 0;
         sum_x_eta = 0;
         sum_y_ksi = 0;
         sum_y_eta = 0;
         errors = 0;
         results_checked = 0;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function longint weight_of(longint inner, bit negate, int shift);
         return clip((negate ? -inner : inner) >>> shift, WGT_MIN, WGT_MAX);
      endfunction

      function void note_node(input logic signed [COORD_W-1:0] ksi, eta,
                              input logic [NODE_W-1:0] node,
                              input logic signed [XY_W-1:0] x, y);
         longint k, e, k2, e2, ke, k2e, ke2, wk, we, lx, ly;
         jacobian_type jac;
         if (node > LAST_NODE) return;
         k = ksi;
         e = eta;
         lx = x;
         ly = y;
         k2 = (k * k) >>> FRAC;
         e2 = (e * e) >>> FRAC;
         ke = (k * e) >>> FRAC;
         k2e = (k2 * e) >>> FRAC;
         ke2 = (k * e2) >>> FRAC;
         case (node)
            NODE_SW: begin
               wk = weight_of(e - 2 * ke - e2 + 2 * ke2, 1'b0, 2);
               we = weight_of(k - k2 - 2 * ke + 2 * k2e, 1'b0, 2);
            end
            NODE_SE: begin
               wk = weight_of(e + 2 * ke - e2 - 2 * ke2, 1'b1, 2);
               we = weight_of(k + k2 - 2 * ke - 2 * k2e, 1'b1, 2);
            end
            NODE_NE: begin
               wk = weight_of(e + 2 * ke + e2 + 2 * ke2, 1'b0, 2);
               we = weight_of(k + k2 + 2 * ke + 2 * k2e, 1'b0, 2);
            end
            NODE_NW: begin
               wk = weight_of(e - 2 * ke + e2 - 2 * ke2, 1'b1, 2);
               we = weight_of(k - k2 + 2 * ke - 2 * k2e, 1'b1, 2);
            end
            NODE_S: begin
               wk = weight_of(-2 * ke + 2 * ke2, 1'b1, 1);
               we = weight_of(ONE_Q14 - k2 - 2 * e + 2 * k2e, 1'b1, 1);
            end
            NODE_E: begin
               wk = weight_of(ONE_Q14 - e2 + 2 * k - 2 * ke2, 1'b0, 1);
               we = weight_of(-2 * ke - 2 * k2e, 1'b0, 1);
            end
            NODE_N: begin
               wk = weight_of(-2 * ke - 2 * ke2, 1'b0, 1);
               we = weight_of(ONE_Q14 - k2 + 2 * e - 2 * k2e, 1'b0, 1);
            end
            NODE_WEST: begin
               wk = weight_of(ONE_Q14 - e2 - 2 * k + 2 * ke2, 1'b1, 1);
               we = weight_of(-2 * ke + 2 * k2e, 1'b1, 1);
            end
            default: begin
               wk = weight_of(2 * ke2 - 2 * k, 1'b0, 0);
               we = weight_of(2 * k2e - 2 * e, 1'b0, 0);
            end
         endcase
         sum_x_ksi = clip(sum_x_ksi + ((wk * lx) >>> FRAC), ACC_MIN, ACC_MAX);
         sum_x_eta = clip(sum_x_eta + ((we * lx) >>> FRAC), ACC_MIN, ACC_MAX);
         sum_y_ksi = clip(sum_y_ksi + ((wk * ly) >>> FRAC), ACC_MIN, ACC_MAX);
         sum_y_eta = clip(sum_y_eta + ((we * ly) >>> FRAC), ACC_MIN, ACC_MAX);
         if (node != LAST_NODE) return;
         jac.dx_dksi = OUT_W'(clip(sum_x_ksi, OUT_MIN, OUT_MAX));
         jac.dx_deta = OUT_W'(clip(sum_x_eta, OUT_MIN, OUT_MAX));
         jac.dy_dksi = OUT_W'(clip(sum_y_ksi, OUT_MIN, OUT_MAX));
         jac.dy_deta = OUT_W'(clip(sum_y_eta, OUT_MIN, OUT_MAX));
         pending_jacobians.push_back(jac);
         sum_x_ksi = 0;
         sum_x_eta = 0;
         sum_y_ksi = 0;
         sum_y_eta = 0;
      endfunction

      function void compare_entry(string label, logic signed [OUT_W-1:0] want, got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         end
      endfunction

      function void check_jacobian(input logic signed [OUT_W-1:0] dx_dksi, dx_deta,
                                   dy_dksi, dy_deta);
         jacobian_type jac;
         if (pending_jacobians.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                     $time, dx_dksi, dx_deta, dy_dksi, dy_deta);
            return;
         end
         jac = pending_jacobians.pop_front();
         results_checked++;
         compare_entry("dx_dksi", jac.dx_dksi, dx_dksi);
         compare_entry("dx_deta", jac.dx_deta, dx_deta);
         compare_entry("dy_dksi", jac.dy_dksi, dy_dksi);
         compare_entry("dy_deta", jac.dy_deta, dy_deta);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [COORD_W-1:0] req_ksi_coord;
   logic signed [COORD_W-1:0] req_eta_coord;
   logic [NODE_W-1:0] req_node_index;
   logic signed [XY_W-1:0] req_node_x;
   logic signed [XY_W-1:0] req_node_y;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [OUT_W-1:0] rsp_dx_dksi;
   logic signed [OUT_W-1:0] rsp_dx_deta;
   logic signed [OUT_W-1:0] rsp_dy_dksi;
   logic signed [OUT_W-1:0] rsp_dy_deta;

   jacobian_tracker tracker;
   int node_ksi [9] = '{-1, 1, 1, -1, 0, 1, 0, -1, 0};
   int node_eta [9] = '{-1, -1, 1, 1, -1, 0, 1, 0, 0};
   int node_items = 0;
   int ignored_items = 0;
   int burst_left = 0;
   bit receiver_hold_req = 1'b0;

   quad9_jacobian_eval_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ksi_coord  (req_ksi_coord),
      .req_eta_coord  (req_eta_coord),
      .req_node_index (req_node_index),
      .req_node_x     (req_node_x),
      .req_node_y     (req_node_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dx_dksi    (rsp_dx_dksi),
      .rsp_dx_deta    (rsp_dx_deta),
      .rsp_dy_dksi    (rsp_dy_dksi),
      .rsp_dy_deta    (rsp_dy_deta)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic offer(input logic signed [COORD_W-1:0] ksi, eta,
                        input logic [NODE_W-1:0] node,
                        input logic signed [XY_W-1:0] x, y);
      int gap;
      req_valid      <= 1'b1;
      req_ksi_coord  <= ksi;
      req_eta_coord  <= eta;
      req_node_index <= node;
      req_node_x     <= x;
      req_node_y     <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_node(ksi, eta, node, x, y);
      if (node > LAST_NODE) ignored_items++;
      else node_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_jacobians.size() != 0);
   endtask

   task automatic send_element();
      logic [NODE_W-1:0] order [9];
      logic [NODE_W-1:0] swap;
      logic signed [COORD_W-1:0] k, e;
      logic signed [XY_W-1:0] cx, cy, half;
      int j, t, jx, jy;
      bit wild;
      wild = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
         0: begin
            k = COORD_W'($urandom);
            e = COORD_W'($urandom);
         end
         1: begin
            k = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
            e = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
         end
         default: begin
            k = COORD_W'($urandom_range(0, 32768) - 16384);
            e = COORD_W'($urandom_range(0, 32768) - 16384);
         end
      endcase
      cx = $urandom_range(0, 1 << 29) - (1 << 28);
      cy = $urandom_range(0, 1 << 29) - (1 << 28);
      half = $urandom_range(1 << 12, 1 << 22);
      for (j = 0; j < 9; j++) order[j] = NODE_W'(j);
      if ($urandom_range(0, 1) != 0) begin
         for (j = 7; j > 0; j--) begin
            t = $urandom_range(0, j);
            swap = order[j];
            order[j] = order[t];
            order[t] = swap;
         end
      end
      for (j = 0; j < 9; j++) begin
         jx = $urandom_range(0, 8191);
         jy = $urandom_range(0, 8191);
         if (wild) begin
            offer(k, e, order[j], $urandom, $urandom);
         end else begin
            offer(k, e, order[j], cx + node_ksi[order[j]] * half + jx - 4096,
                  cy + node_eta[order[j]] * half + jy - 4096);
         end
      end
   endtask

   task automatic send_noise();
      int j, count;
      count = $urandom_range(1, 12);
      for (j = 0; j < count; j++) begin
         offer(COORD_W'($urandom), COORD_W'($urandom), NODE_W'($urandom_range(0, 15)),
               $urandom, $urandom);
      end
   endtask

   task automatic send_overflow_run();
      logic signed [COORD_W-1:0] extreme;
      logic signed [XY_W-1:0] x;
      logic [NODE_W-1:0] node;
      int j;
      extreme = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
      x = ($urandom_range(0, 1) != 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      node = NODE_W'($urandom_range(0, 3));
      for (j = 0; j < OVERFLOW_RUN; j++) offer(extreme, extreme, node, x, ~x);
      offer(extreme, extreme, LAST_NODE, x, ~x);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_jacobian(rsp_dx_dksi, rsp_dx_deta, rsp_dy_dksi, rsp_dy_deta);
      end
   end

   initial begin : result_sink
      int run_len, stall_pct, k;
      forever begin
         if (receiver_hold_req) begin
            receiver_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            for (k = 0; k < LONG_HOLD; k++) @(posedge clock);
         end
         run_len = $urandom_range(4, 160);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 92;
         endcase
         repeat (run_len) begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int j, pick;
      bit hold_done, drain_done;
      logic signed [XY_W-1:0] x;
      tracker = new();
      hold_done = 1'b0;
      drain_done = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_ksi_coord  <= '0;
      req_eta_coord  <= '0;
      req_node_index <= '0;
      req_node_x     <= '0;
      req_node_y     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Unit square at the element center, with an out-of-range node index mixed in.
      offer(16'sd0, 16'sd0, UNUSED_NODE, 32'sh7FFF_FFFF, 32'sh8000_0000);
      for (j = 0; j < 9; j++) begin
         offer(16'sd0, 16'sd0, NODE_W'(j), node_ksi[j] * 65536, node_eta[j] * 65536);
      end
      // Corner of the reference square with extreme coordinates of both signs.
      for (j = 0; j < 9; j++) begin
         x = j[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         offer(16'sd16384, -16'sd16384, NODE_W'(j), x, ~x);
      end
      // Reference point beyond the square, so the weights saturate.
      for (j = 0; j < 9; j++) begin
         offer(16'sh8000, 16'sh7FFF, NODE_W'(j), 32'sh8000_0000, 32'sh7FFF_FFFF);
      end

      while (node_items < ITEM_TARGET) begin
         if (!hold_done && node_items >= ITEM_TARGET / 3) begin
            hold_done = 1'b1;
            receiver_hold_req = 1'b1;
            burst_left = 60;
         end
         if (!drain_done && node_items >= 2 * ITEM_TARGET / 3) begin
            drain_done = 1'b1;
            pause_until_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) send_element();
         else if (pick < 97) send_noise();
         else send_overflow_run();
      end

      req_valid <= 1'b0;
      while (tracker.pending_jacobians.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Summary: %0d node items and %0d ignored items accepted, %0d Jacobians checked.",
               node_items, ignored_items, tracker.results_checked);
      $display("Summary: included saturated weights and outputs, a %0d-cycle result stall.",
               LONG_HOLD);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
